// File: hw/rtl/mlp_online_sgd_trainer_unit_macros.svh
// assertion macros used by the checker file
`ifndef MLP_ONLINE_SGD_TRAINER_UNIT_MACROS_SVH
`define MLP_ONLINE_SGD_TRAINER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define MLP_SGD_AST_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define MLP_SGD_AST_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/mlp_sgd_pkg.sv
// shared constants, types and arithmetic helpers of the perceptron trainer
`timescale 1ns / 1ps
`default_nettype none
package mlp_sgd_pkg;

  localparam int INPUT_COUNT  = 3;
  localparam int HIDDEN_COUNT = 6;
  localparam int OUTPUT_COUNT = 2;

  localparam int W1_BASE      = 0;
  localparam int B1_BASE      = HIDDEN_COUNT * INPUT_COUNT;
  localparam int W2_BASE      = B1_BASE + HIDDEN_COUNT;
  localparam int B2_BASE      = W2_BASE + OUTPUT_COUNT * HIDDEN_COUNT;
  localparam int WEIGHT_TOTAL = B2_BASE + OUTPUT_COUNT;
  localparam int ADDR_W       = 6;

  localparam int ACC_W   = 36;
  localparam int DELTA_W = 30;

  localparam logic [15:0] LR_RESET = 16'd6554;

  localparam logic [1:0] OP_INFER = 2'd0;
  localparam logic [1:0] OP_TRAIN = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  typedef logic signed [15:0] weight_t;
  typedef logic [12:0] prob_t;
  typedef logic [10:0] deriv_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    weight_t           wdata;
    logic [ADDR_W-1:0] raddr;
  } wmem_req_t;

  // piecewise-linear sigmoid on floor(acc / 4096)
  function automatic prob_t sigmoid_q12(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-13:0] z;
    logic [ACC_W-13:0] a;
    prob_t y;
    z = $signed(acc[ACC_W-1:12]);
    a = z[ACC_W-13] ? (ACC_W-12)'(-z) : (ACC_W-12)'(z);
    if (a >= (ACC_W-12)'(20480)) begin
      y = 13'd4096;
    end else if (a >= (ACC_W-12)'(9728)) begin
      y = 13'(a >> 5) + 13'd3456;
    end else if (a >= (ACC_W-12)'(4096)) begin
      y = 13'(a >> 3) + 13'd2560;
    end else begin
      y = 13'(a >> 2) + 13'd2048;
    end
    return z[ACC_W-13] ? 13'd4096 - y : y;
  endfunction

  // y * (1 - y) in q0.12
  function automatic deriv_t deriv_q12(input prob_t y);
    logic [25:0] p;
    p = 26'(y) * 26'(13'd4096 - y);
    return p[22:12];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mlp_sgd_if.sv
// valid/ready channels for request items and result items
`timescale 1ns / 1ps
`default_nettype none
interface mlp_sgd_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  mlp_sgd_pkg::weight_t  feature_0;
  mlp_sgd_pkg::weight_t  feature_1;
  mlp_sgd_pkg::weight_t  feature_2;
  logic [12:0]           target_0;
  logic [12:0]           target_1;
  logic [5:0]            weight_index;
  mlp_sgd_pkg::weight_t  weight_value;

  modport source (output valid, operation, feature_0, feature_1, feature_2,
                  target_0, target_1, weight_index, weight_value, input ready);
  modport sink (input valid, operation, feature_0, feature_1, feature_2,
                target_0, target_1, weight_index, weight_value, output ready);
endinterface

interface mlp_sgd_out_if;
  logic                 valid;
  logic                 ready;
  mlp_sgd_pkg::prob_t   prob_0;
  mlp_sgd_pkg::prob_t   prob_1;
  logic                 label;

  modport source (output valid, prob_0, prob_1, label, input ready);
  modport sink (input valid, prob_0, prob_1, label, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mlp_online_sgd_trainer_unit.sv
// 3-6-2 sigmoid perceptron with online backpropagation training
// Usage:
//   in_ch carries one request item: infer, train step or weight write.
//   out_ch returns exactly one result item per request (probabilities and
//   label; all zero for a write). cfg_wr_en/cfg_wr_data set learning_rate.
// Structure:
//   all 38 weights and biases live in one synchronous ram with a write port
//   and a registered read port; a sequencer walks them in turn, with a read
//   and an accumulate state per weight on the forward pass and read,
//   multiply and write states per weight on the update, plus an activation
//   state per unit on the forward pass and a step setup state per unit on
//   the update.
//   one item is processed at a time; in_ch.ready is high only while idle.
// Reset:
//   rst clears the sequencer and result valid and sets learning_rate to
//   6554; the weight ram is not cleared and must be loaded by writes.
// Stall:
//   a finished result waits in the output register; the unit accepts the
//   next item meanwhile and holds its own next result until the slot frees.
`timescale 1ns / 1ps
`default_nettype none
module mlp_online_sgd_trainer_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [15:0]   cfg_wr_data,
  mlp_sgd_in_if.sink         in_ch,
  mlp_sgd_out_if.source      out_ch
);

  localparam int U_W  = $clog2(mlp_sgd_pkg::HIDDEN_COUNT);
  localparam int J_W  = $clog2(mlp_sgd_pkg::HIDDEN_COUNT + 1);
  localparam int XI_W = $clog2(mlp_sgd_pkg::INPUT_COUNT);
  localparam int OI_W = $clog2(mlp_sgd_pkg::OUTPUT_COUNT);
  localparam int AW   = mlp_sgd_pkg::ADDR_W;
  localparam int ACCW = mlp_sgd_pkg::ACC_W;
  localparam int DW   = mlp_sgd_pkg::DELTA_W;
  localparam int G_W  = 46;
  localparam int LRD_W = DW + 17;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_F_RD  = 4'd1;
  localparam logic [3:0] S_F_MAC = 4'd2;
  localparam logic [3:0] S_F_ACT = 4'd3;
  localparam logic [3:0] S_T_DY  = 4'd4;
  localparam logic [3:0] S_T_DO  = 4'd5;
  localparam logic [3:0] S_H_RD  = 4'd6;
  localparam logic [3:0] S_H_MAC = 4'd7;
  localparam logic [3:0] S_H_LO  = 4'd8;
  localparam logic [3:0] S_H_HI  = 4'd9;
  localparam logic [3:0] S_H_SUM = 4'd10;
  localparam logic [3:0] S_U_LR  = 4'd11;
  localparam logic [3:0] S_U_RD  = 4'd12;
  localparam logic [3:0] S_U_MUL = 4'd13;
  localparam logic [3:0] S_U_WR  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [15:0] lr;
  logic        res_valid;

  logic [1:0]  op;
  mlp_sgd_pkg::weight_t x    [mlp_sgd_pkg::INPUT_COUNT];
  logic [12:0]          tgt  [mlp_sgd_pkg::OUTPUT_COUNT];
  mlp_sgd_pkg::prob_t   hid  [mlp_sgd_pkg::HIDDEN_COUNT];
  mlp_sgd_pkg::prob_t   yout [mlp_sgd_pkg::OUTPUT_COUNT];
  logic signed [DW-1:0] dout [mlp_sgd_pkg::OUTPUT_COUNT];
  logic signed [DW-1:0] dhid [mlp_sgd_pkg::HIDDEN_COUNT];

  logic                  layer;   // 1 selects the output layer
  logic [U_W-1:0]        u;
  logic [J_W-1:0]        j;
  logic signed [ACCW-1:0] acc;
  logic signed [G_W-1:0]  g;
  mlp_sgd_pkg::deriv_t    dreg;
  logic [31:0]            plo;
  logic signed [36:0]     phi;
  logic signed [LRD_W-1:0] lrd;
  mlp_sgd_pkg::weight_t   wreg;
  logic signed [40:0]     ulo;
  logic signed [38:0]     uhi;

  mlp_sgd_pkg::prob_t res_prob0;
  mlp_sgd_pkg::prob_t res_prob1;
  logic               res_label;

  mlp_sgd_pkg::wmem_req_t wreq;
  mlp_sgd_pkg::weight_t   rdata;

  logic                   in_accept;
  logic [J_W-1:0]         fan_in;
  logic                   is_bias;
  logic                   last_unit;
  logic [AW-1:0]          unit_addr;
  logic signed [15:0]     opnd;
  logic signed [31:0]     fprod;
  logic signed [G_W-1:0]  gprod;
  logic signed [DW-1:0]   delta_sel;
  logic signed [59:0]     hsum;
  logic signed [63:0]     usum;
  logic signed [23:0]     step;
  logic signed [24:0]     nw;
  mlp_sgd_pkg::weight_t   nw_sat;
  mlp_sgd_pkg::prob_t     y_act;
  logic [OI_W-1:0]        best;
  logic                   out_free;
  logic                   do_result;

  mlp_sgd_wmem u_wmem (
    .clk   (clk),
    .req   (wreq),
    .rdata (rdata)
  );

  assign in_ch.ready   = (state == S_IDLE);
  assign in_accept     = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = res_valid;
  assign out_ch.prob_0 = res_prob0;
  assign out_ch.prob_1 = res_prob1;
  assign out_ch.label  = res_label;
  assign out_free      = !res_valid || out_ch.ready;
  assign do_result     = (state == S_DONE) && out_free;

  // addressing of the current layer, unit and element
  always_comb begin
    fan_in    = layer ? J_W'(mlp_sgd_pkg::HIDDEN_COUNT) : J_W'(mlp_sgd_pkg::INPUT_COUNT);
    is_bias   = (j == fan_in);
    last_unit = (u == (layer ? U_W'(mlp_sgd_pkg::OUTPUT_COUNT - 1)
                             : U_W'(mlp_sgd_pkg::HIDDEN_COUNT - 1)));
    if (layer) begin
      unit_addr = is_bias ? AW'(mlp_sgd_pkg::B2_BASE) + AW'(u)
                          : AW'(mlp_sgd_pkg::W2_BASE)
                            + AW'(u) * AW'(mlp_sgd_pkg::HIDDEN_COUNT) + AW'(j);
    end else begin
      unit_addr = is_bias ? AW'(mlp_sgd_pkg::B1_BASE) + AW'(u)
                          : AW'(mlp_sgd_pkg::W1_BASE)
                            + AW'(u) * AW'(mlp_sgd_pkg::INPUT_COUNT) + AW'(j);
    end
  end

  // weight ram port
  always_comb begin
    wreq.raddr = (state == S_H_RD)
               ? AW'(mlp_sgd_pkg::W2_BASE) + AW'(j) * AW'(mlp_sgd_pkg::HIDDEN_COUNT) + AW'(u)
               : unit_addr;
    if (state == S_U_WR) begin
      wreq.we    = 1'b1;
      wreq.waddr = unit_addr;
      wreq.wdata = nw_sat;
    end else begin
      wreq.we    = in_accept && (in_ch.operation == mlp_sgd_pkg::OP_WRITE)
                   && (in_ch.weight_index < AW'(mlp_sgd_pkg::WEIGHT_TOTAL));
      wreq.waddr = in_ch.weight_index;
      wreq.wdata = in_ch.weight_value;
    end
  end

  // arithmetic
  always_comb begin
    if (is_bias) begin
      opnd = 16'sd4096;
    end else if (layer) begin
      opnd = $signed({3'b000, hid[j]});
    end else begin
      opnd = x[j[XI_W-1:0]];
    end
    fprod     = 32'(rdata) * 32'(opnd);
    gprod     = G_W'(rdata) * G_W'(dout[j[OI_W-1:0]]);
    delta_sel = layer ? dout[u[OI_W-1:0]] : dhid[u];
    hsum      = (60'(phi) <<< 21) + $signed(60'(plo));
    usum      = (64'(uhi) <<< 24) + 64'(ulo);
    // bias step is floor(lr * delta / 2^28), weight step floor(lr * delta * in / 2^40)
    step      = is_bias ? 24'($signed(lrd[LRD_W-1:28])) : $signed(usum[63:40]);
    nw        = 25'(wreg) - 25'(step);
    if (nw > 25'sd32767) begin
      nw_sat = 16'sh7fff;
    end else if (nw < -25'sd32768) begin
      nw_sat = 16'sh8000;
    end else begin
      nw_sat = nw[15:0];
    end
    y_act = mlp_sgd_pkg::sigmoid_q12(acc);
    best  = '0;
    for (int o = 1; o < mlp_sgd_pkg::OUTPUT_COUNT; o++) begin
      if (yout[o] > yout[best]) begin
        best = OI_W'(o);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (in_ch.operation == mlp_sgd_pkg::OP_INFER
              || in_ch.operation == mlp_sgd_pkg::OP_TRAIN) begin
            state_next = S_F_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_F_RD:  state_next = S_F_MAC;
      S_F_MAC: state_next = is_bias ? S_F_ACT : S_F_RD;
      S_F_ACT: begin
        if (last_unit && layer) begin
          state_next = (op == mlp_sgd_pkg::OP_TRAIN) ? S_T_DY : S_DONE;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_T_DY:  state_next = S_T_DO;
      S_T_DO:  state_next = (u == U_W'(mlp_sgd_pkg::OUTPUT_COUNT - 1)) ? S_H_RD : S_T_DY;
      S_H_RD:  state_next = S_H_MAC;
      S_H_MAC: state_next = (j == J_W'(mlp_sgd_pkg::OUTPUT_COUNT - 1)) ? S_H_LO : S_H_RD;
      S_H_LO:  state_next = S_H_HI;
      S_H_HI:  state_next = S_H_SUM;
      S_H_SUM: begin
        state_next = (u == U_W'(mlp_sgd_pkg::HIDDEN_COUNT - 1)) ? S_U_LR : S_H_RD;
      end
      S_U_LR:  state_next = S_U_RD;
      S_U_RD:  state_next = S_U_MUL;
      S_U_MUL: state_next = S_U_WR;
      S_U_WR: begin
        if (!is_bias) begin
          state_next = S_U_RD;
        end else if (last_unit && !layer) begin
          state_next = S_DONE;
        end else begin
          state_next = S_U_LR;
        end
      end
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lr        <= mlp_sgd_pkg::LR_RESET;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        lr <= cfg_wr_data;
      end
      if (do_result) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op    <= in_ch.operation;
        x[0]  <= in_ch.feature_0;
        x[1]  <= in_ch.feature_1;
        x[2]  <= in_ch.feature_2;
        tgt[0] <= in_ch.target_0;
        tgt[1] <= in_ch.target_1;
        layer <= 1'b0;
        u     <= '0;
        j     <= '0;
        acc   <= '0;
      end
      S_F_MAC: begin
        acc <= acc + ACCW'(fprod);
        if (!is_bias) begin
          j <= j + 1'b1;
        end
      end
      S_F_ACT: begin
        if (layer) begin
          yout[u[OI_W-1:0]] <= y_act;
        end else begin
          hid[u] <= y_act;
        end
        acc <= '0;
        j   <= '0;
        if (last_unit) begin
          layer <= 1'b1;
          u     <= '0;
        end else begin
          u <= u + 1'b1;
        end
      end
      S_T_DY: dreg <= mlp_sgd_pkg::deriv_q12(yout[u[OI_W-1:0]]);
      S_T_DO: begin
        // output delta (y - t) * y(1 - y)
        dout[u[OI_W-1:0]] <= DW'(($signed(14'(yout[u[OI_W-1:0]])) - $signed(14'(tgt[u[OI_W-1:0]])))
                                 * $signed({1'b0, dreg}));
        if (u == U_W'(mlp_sgd_pkg::OUTPUT_COUNT - 1)) begin
          u <= '0;
          j <= '0;
          g <= '0;
        end else begin
          u <= u + 1'b1;
        end
      end
      S_H_RD: dreg <= mlp_sgd_pkg::deriv_q12(hid[u]);
      S_H_MAC: begin
        g <= g + gprod;
        if (j != J_W'(mlp_sgd_pkg::OUTPUT_COUNT - 1)) begin
          j <= j + 1'b1;
        end
      end
      // back-propagated sum times derivative, split into two narrow products
      S_H_LO: plo <= 32'(g[20:0]) * 32'(dreg);
      S_H_HI: phi <= 37'($signed(g[G_W-1:21])) * 37'($signed({1'b0, dreg}));
      S_H_SUM: begin
        dhid[u] <= hsum[DW+23:24];
        g <= '0;
        j <= '0;
        if (u == U_W'(mlp_sgd_pkg::HIDDEN_COUNT - 1)) begin
          u <= '0;
        end else begin
          u <= u + 1'b1;
        end
      end
      S_U_LR: begin
        lrd <= LRD_W'($signed({1'b0, lr})) * LRD_W'(delta_sel);
        j   <= '0;
      end
      S_U_MUL: begin
        wreg <= rdata;
        ulo  <= 41'($signed({1'b0, lrd[23:0]})) * 41'(opnd);
        uhi  <= 39'($signed(lrd[LRD_W-1:24])) * 39'(opnd);
      end
      S_U_WR: begin
        if (!is_bias) begin
          j <= j + 1'b1;
        end else if (last_unit) begin
          layer <= 1'b0;
          u     <= '0;
        end else begin
          u <= u + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (op == mlp_sgd_pkg::OP_INFER || op == mlp_sgd_pkg::OP_TRAIN) begin
            res_prob0 <= yout[0];
            res_prob1 <= yout[1];
            res_label <= best[0];
          end else begin
            res_prob0 <= '0;
            res_prob1 <= '0;
            res_label <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/mlp_sgd_wmem.sv
// weight and bias store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module mlp_sgd_wmem (
  input  wire logic                   clk,
  input  wire mlp_sgd_pkg::wmem_req_t req,
  output mlp_sgd_pkg::weight_t        rdata
);

  mlp_sgd_pkg::weight_t mem [mlp_sgd_pkg::WEIGHT_TOTAL];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/mlp_sgd_checker.sv
// port-level checks of the trainer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "mlp_online_sgd_trainer_unit_macros.svh"
module mlp_sgd_checker (
  input wire logic      clk,
  input wire logic      rst,
  mlp_sgd_in_if.sink    in_ch,
  mlp_sgd_out_if.source out_ch
);

  `MLP_SGD_AST_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped while stalled")
  `MLP_SGD_AST_NEXT(a_busy, in_ch.valid && in_ch.ready, !in_ch.ready, "item taken while busy")
  `MLP_SGD_AST_NOW(a_prob_range, out_ch.valid, out_ch.prob_0 <= 13'd4096 && out_ch.prob_1 <= 13'd4096, "probability above one")
  `MLP_SGD_AST_NOW(a_label, out_ch.valid, out_ch.label == (out_ch.prob_1 > out_ch.prob_0), "label not the argmax")

endmodule

bind mlp_online_sgd_trainer_unit mlp_sgd_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
`default_nettype wire
